@@ rtl/lcst_pkg.sv @@
// Shared types and codes for the least-connections server table.
package lcst_pkg;

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_DELETE = 2'd1,
    CMD_UPDATE = 2'd2,
    CMD_PICK   = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    STAT_OK       = 2'd0,
    STAT_EMPTY    = 2'd1,
    STAT_NOTFOUND = 2'd2,
    STAT_FULL     = 2'd3
  } status_t;

  // Operation broadcast to every cell of the chain.
  typedef enum logic [1:0] {
    OP_HOLD,
    OP_REMOVE,
    OP_INSERT
  } cell_op_t;

  typedef enum logic {
    S_IDLE,
    S_PLACE
  } state_t;

  typedef struct packed {
    cell_op_t op;
    logic     pick_front;
  } cell_ctrl_t;

  localparam int PortWidth = 16;

endpackage

@@ rtl/least_connections_server_table.sv @@
// Top level of the least-connections server table: control and the chain of cells.
//
//  channel | handshake            | payload
//  --------+----------------------+------------------------------------------------
//  input   | in_valid / in_stall  | cmd, port_number, connection_count
//  output  | out_valid / out_stall| status, picked_port, picked_count, occupancy
//
// Insert, delete and every error case finish in the cycle the item is taken;
// the result is registered at that edge. Update and pick pass through S_IDLE and
// S_PLACE: the matching entry leaves the chain in S_IDLE and is placed again in S_PLACE.
// The cell chain's broadcast compare and shift act on every cell at once.
// Reset empties the table by clearing the cell valid bits.
// A stalled result holds the output register and the block takes no new item.
module least_connections_server_table #(
  parameter int MAX_SERVERS = 16,
  parameter int COUNT_WIDTH = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  cmd,
  input  logic [15:0] port_number,
  input  logic [15:0] connection_count,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  status,
  output logic [15:0] picked_port,
  output logic [15:0] picked_count,
  output logic [4:0]  occupancy
);
  import lcst_pkg::*;

  localparam int TW = $clog2(MAX_SERVERS + 1);

  // Chain taps: one entry per cell, read by its neighbors; control also reads the head and the last hit.
  logic                   cv  [MAX_SERVERS];
  logic [PortWidth-1:0]   cp  [MAX_SERVERS];
  logic [COUNT_WIDTH-1:0] cc  [MAX_SERVERS];
  logic                   cgt [MAX_SERVERS];
  logic                   chit[MAX_SERVERS];

  state_t                 state, state_next;
  logic [TW-1:0]          total, total_next;
  logic [PortWidth-1:0]   hold_port, hold_port_next;
  logic [COUNT_WIDTH-1:0] hold_count, hold_count_next;
  logic                   hold_pick, hold_pick_next;

  cell_ctrl_t             ctrl;
  logic [PortWidth-1:0]   key_port;
  logic [COUNT_WIDTH-1:0] key_count;
  logic [COUNT_WIDTH-1:0] cnt_in;
  logic [COUNT_WIDTH-1:0] front_inc;
  logic                   accept, empty, full, found;

  logic                   load;
  status_t                res_status;
  logic [15:0]            res_port, res_count;

  assign cnt_in    = COUNT_WIDTH'(connection_count);
  assign front_inc = (cc[0] == {COUNT_WIDTH{1'b1}}) ? cc[0] : cc[0] + COUNT_WIDTH'(1);
  assign empty     = (total == '0);
  assign full      = (total == TW'(MAX_SERVERS));
  // The hit chain leaves the last cell set when some entry matched.
  assign found     = chit[MAX_SERVERS-1];

  assign in_stall = (state == S_PLACE) || (out_valid && out_stall);
  assign accept   = in_valid && !in_stall;

  always_comb begin
    state_next      = state;
    total_next      = total;
    hold_port_next  = hold_port;
    hold_count_next = hold_count;
    hold_pick_next  = hold_pick;
    ctrl.op         = OP_HOLD;
    ctrl.pick_front = (cmd == CMD_PICK);
    key_port        = port_number;
    key_count       = cnt_in;
    load            = 1'b0;
    res_status      = STAT_OK;
    res_port        = '0;
    res_count       = '0;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          unique case (cmd)
            CMD_INSERT: begin
              load = 1'b1;
              if (full) begin
                res_status = STAT_FULL;
              end else begin
                ctrl.op    = OP_INSERT;
                total_next = total + TW'(1);
              end
            end
            CMD_DELETE: begin
              load = 1'b1;
              if (empty) begin
                res_status = STAT_EMPTY;
              end else if (!found) begin
                res_status = STAT_NOTFOUND;
              end else begin
                ctrl.op    = OP_REMOVE;
                total_next = total - TW'(1);
              end
            end
            CMD_UPDATE, CMD_PICK: begin
              if (empty) begin
                load       = 1'b1;
                res_status = STAT_EMPTY;
              end else if (!found) begin
                load       = 1'b1;
                res_status = STAT_NOTFOUND;
              end else begin
                // Pull the entry out now and place it again next cycle.
                ctrl.op        = OP_REMOVE;
                hold_pick_next = (cmd == CMD_PICK);
                if (cmd == CMD_PICK) begin
                  hold_port_next  = cp[0];
                  hold_count_next = front_inc;
                end else begin
                  hold_port_next  = port_number;
                  hold_count_next = cnt_in;
                end
                state_next = S_PLACE;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_PLACE: begin
        // The table is one entry short here, so there is always room.
        ctrl.op    = OP_INSERT;
        key_port   = hold_port;
        key_count  = hold_count;
        load       = 1'b1;
        if (hold_pick) begin
          res_port  = hold_port;
          res_count = 16'(hold_count);
        end
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Cell row. The head sees a full, smaller left neighbor; the tail sees empty space.
  for (genvar i = 0; i < MAX_SERVERS; i++) begin : g_cell
    logic                   lv, lg, hi, rv;
    logic [PortWidth-1:0]   lp, rp;
    logic [COUNT_WIDTH-1:0] lc, rc;

    if (i == 0) begin : g_head
      assign lv = 1'b1;
      assign lg = 1'b0;
      assign lp = '0;
      assign lc = '0;
      assign hi = 1'b0;
    end else begin : g_mid
      assign lv = cv[i-1];
      assign lg = cgt[i-1];
      assign lp = cp[i-1];
      assign lc = cc[i-1];
      assign hi = chit[i-1];
    end

    if (i == MAX_SERVERS - 1) begin : g_tail
      assign rv = 1'b0;
      assign rp = '0;
      assign rc = '0;
    end else begin : g_body
      assign rv = cv[i+1];
      assign rp = cp[i+1];
      assign rc = cc[i+1];
    end

    lcst_cell #(.CW(COUNT_WIDTH)) u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctrl       (ctrl),
      .key_port   (key_port),
      .key_count  (key_count),
      .left_valid (lv),
      .left_gt    (lg),
      .left_port  (lp),
      .left_count (lc),
      .hit_in     (hi),
      .right_valid(rv),
      .right_port (rp),
      .right_count(rc),
      .valid      (cv[i]),
      .port       (cp[i]),
      .count      (cc[i]),
      .gt         (cgt[i]),
      .hit_out    (chit[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      total     <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      total <= total_next;
      if (load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
    hold_port  <= hold_port_next;
    hold_count <= hold_count_next;
    hold_pick  <= hold_pick_next;
    if (load) begin
      status       <= res_status;
      picked_port  <= res_port;
      picked_count <= res_count;
      occupancy    <= 5'(total_next);
    end
  end

endmodule

@@ rtl/lcst_cell.sv @@
// One slot of the sorted server chain: holds a port and a count, shifts with its neighbors.
module lcst_cell #(
  parameter int CW = 16
) (
  input  logic                       clk,
  input  logic                       rst,
  input  lcst_pkg::cell_ctrl_t       ctrl,
  input  logic [lcst_pkg::PortWidth-1:0] key_port,
  input  logic [CW-1:0]              key_count,
  input  logic                       left_valid,
  input  logic                       left_gt,
  input  logic [lcst_pkg::PortWidth-1:0] left_port,
  input  logic [CW-1:0]              left_count,
  input  logic                       hit_in,
  input  logic                       right_valid,
  input  logic [lcst_pkg::PortWidth-1:0] right_port,
  input  logic [CW-1:0]              right_count,
  output logic                       valid,
  output logic [lcst_pkg::PortWidth-1:0] port,
  output logic [CW-1:0]              count,
  output logic                       gt,
  output logic                       hit_out
);
  import lcst_pkg::*;

  logic                 valid_next;
  logic [PortWidth-1:0] port_next;
  logic [CW-1:0]        count_next;
  logic                 match;

  // An entry matches the front on a pick, or its port otherwise.
  assign match   = valid && (ctrl.pick_front || (port == key_port));
  assign hit_out = hit_in || match;
  assign gt      = valid && (count > key_count);

  always_comb begin
    valid_next = valid;
    port_next  = port;
    count_next = count;
    unique case (ctrl.op)
      OP_HOLD: begin
      end
      OP_REMOVE: begin
        // The removed slot and everything behind it pull from the right.
        if (hit_out) begin
          valid_next = right_valid;
          port_next  = right_port;
          count_next = right_count;
        end
      end
      OP_INSERT: begin
        if (left_gt) begin
          valid_next = 1'b1;
          port_next  = left_port;
          count_next = left_count;
        end else if (gt || (!valid && left_valid)) begin
          valid_next = 1'b1;
          port_next  = key_port;
          count_next = key_count;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= valid_next;
    end
    port  <= port_next;
    count <= count_next;
  end

endmodule

@@ tb/server_table_checker.sv @@
// Checker for the least-connections server table: predicts every result and compares it.
module server_table_checker
  import lcst_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [1:0]  cmd,
  input  logic [15:0] port_number,
  input  logic [15:0] connection_count,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [1:0]  status,
  input  logic [15:0] picked_port,
  input  logic [15:0] picked_count,
  input  logic [4:0]  occupancy,
  output int          errors,
  output int          pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TableDepth = 16;
  localparam logic [15:0] CountMax = 16'hFFFF;

  typedef struct {
    status_t     status;
    logic [15:0] port;
    logic [15:0] count;
    logic [4:0]  occupancy;
  } table_result_t;

  // Shadow of the sorted table, ascending by count, oldest first among equals.
  logic [15:0] slot_port [TableDepth];
  logic [15:0] slot_count[TableDepth];
  int          slot_total;

  table_result_t awaited_results[$];

  function automatic void drop_slot(int idx);
    for (int i = idx; i + 1 < slot_total; i++) begin
      slot_port[i]  = slot_port[i + 1];
      slot_count[i] = slot_count[i + 1];
    end
    slot_total--;
  endfunction

  // The new entry goes in front of the first entry with a strictly larger count.
  function automatic void place_slot(logic [15:0] port, logic [15:0] count);
    int pos;
    pos = slot_total;
    for (int i = 0; i < slot_total; i++) begin
      if (slot_count[i] > count) begin
        pos = i;
        break;
      end
    end
    for (int i = slot_total; i > pos; i--) begin
      slot_port[i]  = slot_port[i - 1];
      slot_count[i] = slot_count[i - 1];
    end
    slot_port[pos]  = port;
    slot_count[pos] = count;
    slot_total++;
  endfunction

  function automatic int find_slot(logic [15:0] port);
    for (int i = 0; i < slot_total; i++) begin
      if (slot_port[i] == port) return i;
    end
    return -1;
  endfunction

  function automatic table_result_t apply_command(logic [1:0] op, logic [15:0] port,
                                                  logic [15:0] count);
    table_result_t res;
    int          idx;
    logic [15:0] front_port;
    logic [15:0] front_count;
    res.status = STAT_OK;
    res.port   = '0;
    res.count  = '0;
    case (cmd_t'(op))
      CMD_INSERT: begin
        if (slot_total >= TableDepth) res.status = STAT_FULL;
        else place_slot(port, count);
      end
      CMD_DELETE, CMD_UPDATE: begin
        idx = find_slot(port);
        if (slot_total == 0) begin
          res.status = STAT_EMPTY;
        end else if (idx < 0) begin
          res.status = STAT_NOTFOUND;
        end else begin
          drop_slot(idx);
          if (cmd_t'(op) == CMD_UPDATE) place_slot(port, count);
        end
      end
      default: begin
        if (slot_total == 0) begin
          res.status = STAT_EMPTY;
        end else begin
          front_port  = slot_port[0];
          front_count = slot_count[0];
          if (front_count != CountMax) front_count++;
          drop_slot(0);
          place_slot(front_port, front_count);
          res.port  = front_port;
          res.count = front_count;
        end
      end
    endcase
    res.occupancy = 5'(slot_total);
    return res;
  endfunction

  task automatic report_failure(string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    errors++;
  endtask

  initial begin
    errors     = 0;
    pending    = 0;
    slot_total = 0;
  end

  always @(posedge clk) begin
    table_result_t want;
    if (rst) begin
      slot_total = 0;
      awaited_results.delete();
    end else begin
      // Results are taken before new items so that a result is never matched
      // against an item accepted at the same edge.
      if (out_valid && !out_stall) begin
        if (awaited_results.size() == 0) begin
          report_failure($sformatf("result with nothing outstanding, status %0d", status));
        end else begin
          want = awaited_results.pop_front();
          if (status != want.status)
            report_failure($sformatf("status %0d, expected %0d", status, want.status));
          if (picked_port != want.port)
            report_failure($sformatf("picked_port %h, expected %h", picked_port, want.port));
          if (picked_count != want.count)
            report_failure($sformatf("picked_count %h, expected %h", picked_count, want.count));
          if (occupancy != want.occupancy)
            report_failure($sformatf("occupancy %0d, expected %0d", occupancy,
                                     want.occupancy));
        end
      end
      if (in_valid && !in_stall)
        awaited_results.push_back(apply_command(cmd, port_number, connection_count));
    end
    pending = awaited_results.size();
  end

endmodule

@@ tb/tb_least_connections_server_table.sv @@
// Testbench top for the least-connections server table: stimulus, flow control and verdict.
module tb_least_connections_server_table;
  import lcst_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  // Nothing accepted on either channel for this many cycles ends the run. The
  // longest quiet stretch of a correct run is the receiver's long hold-off
  // (PressureHold) plus a sender gap, so this leaves a wide margin.
  localparam int WatchdogLimit = 3000;
  localparam int PressureHold  = 300;
  localparam int PhaseItems    = 200;
  localparam int PhaseCount    = 8;

  logic        clk;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  cmd = CMD_INSERT;
  logic [15:0] port_number = '0;
  logic [15:0] connection_count = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  status;
  logic [15:0] picked_port;
  logic [15:0] picked_count;
  logic [4:0]  occupancy;

  int errors;
  int pending;
  int results_taken = 0;
  int idle_cycles = 0;

  // While set, neither side inserts gaps, so back-to-back traffic is covered too.
  bit no_gaps = 1'b0;

  // Ports are mostly drawn from a small pool so that deletes and updates find
  // their target and duplicates arise; the pool is refreshed every phase.
  logic [15:0] port_pool[8];

  least_connections_server_table u_top (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .cmd              (cmd),
    .port_number      (port_number),
    .connection_count (connection_count),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .status           (status),
    .picked_port      (picked_port),
    .picked_count     (picked_count),
    .occupancy        (occupancy)
  );

  server_table_checker u_checker (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .cmd              (cmd),
    .port_number      (port_number),
    .connection_count (connection_count),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .status           (status),
    .picked_port      (picked_port),
    .picked_count     (picked_count),
    .occupancy        (occupancy),
    .errors           (errors),
    .pending          (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Gap lengths: mostly none, often a few cycles, now and then a long one.
  function automatic int gap_length();
    int r;
    r = $urandom_range(0, 99);
    if (no_gaps || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 40);
  endfunction

  // Presents one item at the falling edge and holds it until the block takes it.
  // The valid line gets exactly one assignment per falling edge.
  task automatic send_item(cmd_t op, logic [15:0] port, logic [15:0] count);
    int gap;
    gap = gap_length();
    repeat (gap) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid         <= 1'b1;
    cmd              <= op;
    port_number      <= port;
    connection_count <= count;
    do @(posedge clk); while (in_stall);
  endtask

  function automatic logic [15:0] random_port();
    if ($urandom_range(0, 99) < 85) return port_pool[$urandom_range(0, 7)];
    return 16'($urandom_range(0, 65535));
  endfunction

  // Many small counts give ties; counts at the top of the range reach saturation.
  function automatic logic [15:0] random_count();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 16'($urandom_range(0, 4));
    if (r < 70) return 16'($urandom_range(65533, 65535));
    return 16'($urandom_range(0, 65535));
  endfunction

  // Fill phases lean toward inserts so the table reaches full; drain phases
  // lean toward deletes so it empties again.
  function automatic cmd_t random_command(bit filling);
    int r;
    r = $urandom_range(0, 99);
    if (filling) begin
      if (r < 50) return CMD_INSERT;
      if (r < 65) return CMD_DELETE;
      if (r < 80) return CMD_UPDATE;
      return CMD_PICK;
    end
    if (r < 20) return CMD_INSERT;
    if (r < 60) return CMD_DELETE;
    if (r < 80) return CMD_UPDATE;
    return CMD_PICK;
  endfunction

  // Receiver: random stalls, plus one long hold-off once traffic is under way
  // so the result register stays occupied and the block stalls its input.
  initial begin
    int  hold;
    int  run;
    bit  pressure_done;
    pressure_done = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (!pressure_done && results_taken >= 700) begin
        pressure_done = 1'b1;
        hold = PressureHold;
      end else begin
        hold = gap_length();
      end
      repeat (hold) begin
        @(negedge clk);
        out_stall <= 1'b1;
      end
      run = no_gaps ? 20 : $urandom_range(1, 12);
      repeat (run) begin
        @(negedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) results_taken <= results_taken + 1;
  end

  // Watchdog: counts cycles in which neither channel moves an item.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WatchdogLimit) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    repeat (10) @(negedge clk);
    rst <= 1'b0;

    // Directed part. Pick, delete and update on an empty table must report empty.
    send_item(CMD_PICK,   16'h0005, 16'h0000);
    send_item(CMD_DELETE, 16'h0005, 16'h0000);
    send_item(CMD_UPDATE, 16'h0005, 16'h0007);
    // A lone entry at the maximum count: the pick saturates and keeps it there.
    send_item(CMD_INSERT, 16'hFFFF, 16'hFFFF);
    send_item(CMD_PICK,   16'h0000, 16'h0000);
    // An equal count lines up behind; a saturated pick then goes behind its peer.
    send_item(CMD_INSERT, 16'h0000, 16'hFFFF);
    send_item(CMD_PICK,   16'h0000, 16'h0000);
    send_item(CMD_PICK,   16'h0000, 16'h0000);
    // Ties at zero and a duplicate port with a different count.
    send_item(CMD_INSERT, 16'h5555, 16'h0000);
    send_item(CMD_INSERT, 16'hAAAA, 16'h0000);
    send_item(CMD_INSERT, 16'h5555, 16'h1234);
    // Absent ports are reported as not found and leave the table alone.
    send_item(CMD_DELETE, 16'h1111, 16'h0000);
    send_item(CMD_UPDATE, 16'h2222, 16'h0001);
    // Update and delete act on the first matching entry in sorted order; the
    // updated entry lands behind the entries with an equal count.
    send_item(CMD_UPDATE, 16'h5555, 16'h0000);
    send_item(CMD_DELETE, 16'h5555, 16'h0000);
    // Fill the table to its limit, then one insert more is refused as full.
    for (int i = 0; i < 12; i++)
      send_item(CMD_INSERT, 16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)));
    send_item(CMD_INSERT, 16'h1357, 16'h0002);
    send_item(CMD_PICK,   16'h0000, 16'h0000);

    // Random part, in phases that alternate between filling and draining.
    for (int phase = 0; phase < PhaseCount; phase++) begin
      foreach (port_pool[k]) port_pool[k] = 16'($urandom_range(0, 65535));
      no_gaps = (phase == 2 || phase == 5);
      for (int n = 0; n < PhaseItems; n++)
        send_item(random_command(phase % 2 == 0), random_port(), random_count());
    end
    no_gaps = 1'b0;
    @(negedge clk);
    in_valid <= 1'b0;

    // Drain: wait for every outstanding result, then wait on so that a
    // stray extra result would still be seen.
    while (pending != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    if (errors == 0 && pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
